// ===== hdl/btint_pkg.sv =====
// shared constants and types for the border table interpolator
`timescale 1ns / 1ps

package btint_pkg;

	localparam int MAX_BORDERS_DEF = 64;
	localparam int VALUE_BITS_DEF  = 32;

	localparam int COUNT_W  = 7;
	localparam int ENTRY_W  = 6;
	localparam int SAMPLE_W = 32;
	localparam int STATUS_W = 2;
	localparam int PCT_W    = 23;
	localparam int BIT_W    = $clog2(PCT_W);

	// 100 * 2^16
	localparam logic [PCT_W-1:0] PERCENT_SCALE = PCT_W'(6553600);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_UNCFG = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CMD_QUERY = 1'b0,
		CMD_WRITE = 1'b1
	} command_t;

endpackage

// ===== hdl/border_table_interpolator.sv =====
// top level: border table memory, bin search sequencer and result register
`timescale 1ns / 1ps
// writes: a write takes effect at its accepting edge and gives no result; an unconfigured
//   query goes straight to the result state, a configured one first scans the table and, when
//   in range, runs the ratio unit; the result waits there until the output register is free
// throughput: one item at a time, set by the linear scan through the single read port of
//   the table (one entry a cycle) and the 23-step bit-serial ratio unit
// reset: sequencer, output valid flag and border count register clear; table contents stay undefined

module border_table_interpolator import btint_pkg::*; #(
	parameter int MAX_BORDERS = MAX_BORDERS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// item channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic [ENTRY_W-1:0]  entry_index,
	input  logic [SAMPLE_W-1:0] sample_value,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  bin_index,
	output logic [PCT_W-1:0]    percent_q16,
	// configuration channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [COUNT_W-1:0]  border_count
);

	localparam int AW = $clog2(MAX_BORDERS);
	localparam int NW = VALUE_BITS + COUNT_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;

	// configuration register
	logic [COUNT_W-1:0] count_q;

	// query context
	logic [VALUE_BITS-1:0] v_q;
	logic [COUNT_W-1:0]    n_q;
	logic [COUNT_W-1:0]    nm1_q;
	logic [VALUE_BITS-1:0] prev_q;
	logic [VALUE_BITS-1:0] d_q;
	logic [VALUE_BITS-1:0] vml_q;
	logic [COUNT_W-1:0]    jm1_q;

	// pending result, waits here until the output register is free
	status_t            res_status_q;
	logic [COUNT_W-1:0] res_bin_q;
	logic [PCT_W-1:0]   res_pct_q;

	// output register
	logic               out_valid_q;
	status_t            status_q;
	logic [COUNT_W-1:0] bin_q;
	logic [PCT_W-1:0]   pct_q;

	// table memory and its read stage
	logic [VALUE_BITS-1:0] mem [MAX_BORDERS];
	logic [VALUE_BITS-1:0] rdata_s1;
	logic                  rd_vld_s1;
	logic [COUNT_W-1:0]    rd_j_s1;
	logic [COUNT_W-1:0]    addr_q;

	logic                  in_take;
	logic                  mem_we;
	logic                  rd_en;
	logic                  scan_hit;
	logic                  scan_ovf;
	logic                  out_free;
	logic [VALUE_BITS-1:0] v_in;
	logic [COUNT_W-1:0]    n_in;

	logic                  div_start;
	logic                  div_done;
	logic [NW-1:0]         div_num;
	logic [NW-1:0]         div_den;
	logic [PCT_W-1:0]      div_quot;

	// one item at a time: the sequencer only listens when idle
	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// sample taken modulo 2^VALUE_BITS
	assign v_in = VALUE_BITS'(sample_value);

	// count above the table depth uses the whole table
	assign n_in = (int'(count_q) > MAX_BORDERS) ? COUNT_W'(MAX_BORDERS) : count_q;

	// out of range writes are dropped
	assign mem_we = in_take && (command == CMD_WRITE) && (int'(entry_index) < MAX_BORDERS);

	// stream reads 0,1,2.. while scanning; compare lands in the cycle after the read
	assign rd_en    = (state_q == S_SCAN) && (addr_q < n_q);
	assign scan_hit = rd_vld_s1 && (v_q < rdata_s1);
	assign scan_ovf = rd_vld_s1 && !scan_hit && (rd_j_s1 == nm1_q);

	assign out_free = !out_valid_q || !out_stall;

	// numerator and denominator of the ratio, one narrow multiply each
	assign div_start = (state_q == S_MUL);
	assign div_num   = NW'(NW'(jm1_q) * NW'(d_q)) + NW'(vml_q);
	assign div_den   = NW'(NW'(nm1_q) * NW'(d_q));

	btint_div #(
		.VALUE_BITS (VALUE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// border table, synchronous write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(entry_index)] <= v_in;
		end
		if (rd_en) begin
			rdata_s1 <= mem[AW'(addr_q)];
		end
	end

	// configuration transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= border_count;
		end
	end

	// sequencer and read-stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_vld_s1 <= 1'b0;
			rd_j_s1   <= '0;
			addr_q    <= '0;
		end else begin
			rd_vld_s1 <= rd_en && !scan_hit && !scan_ovf;
			rd_j_s1   <= addr_q;
			if (rd_en) begin
				addr_q <= addr_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					addr_q <= '0;
					if (in_take && command == CMD_QUERY) begin
						state_q <= (n_in < COUNT_W'(3)) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						state_q <= (rd_j_s1 == '0) ? S_DONE : S_MUL;
					end else if (scan_ovf) begin
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// query context and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				v_q          <= v_in;
				n_q          <= n_in;
				nm1_q        <= n_in - 1'b1;
				res_status_q <= ST_UNCFG;
				res_bin_q    <= '0;
				res_pct_q    <= '0;
			end
			S_SCAN: begin
				if (scan_hit) begin
					res_bin_q <= rd_j_s1;
					if (rd_j_s1 == '0) begin
						res_status_q <= ST_UNDER;
					end else begin
						res_status_q <= ST_OK;
						// prev_q holds border[j-1], so d is positive and v minus border[j-1] is not negative
						d_q          <= rdata_s1 - prev_q;
						vml_q        <= v_q - prev_q;
						jm1_q        <= rd_j_s1 - 1'b1;
					end
				end else if (scan_ovf) begin
					res_status_q <= ST_OVER;
					res_bin_q    <= n_q;
				end else if (rd_vld_s1) begin
					prev_q <= rdata_s1;
				end
			end
			S_DIV: begin
				if (div_done) begin
					res_pct_q <= div_quot;
				end
			end
			default: begin
			end
		endcase
	end

	// output register, frees itself when the receiver takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q <= res_status_q;
			bin_q    <= res_bin_q;
			pct_q    <= res_pct_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign bin_index   = bin_q;
	assign percent_q16 = pct_q;

	// read data only ever comes back while scanning
	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == S_SCAN)
		else $error("table read returned outside the scan");

	// the ratio unit answers only the query that started it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("ratio result with no query waiting for it");

	a_mul_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |=> state_q == S_DIV)
		else $error("ratio unit start not followed by wait");

	// flagged results carry no percentage
	a_pct_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> pct_q == '0)
		else $error("percentage on a flagged result");

	// an in-range bin always has a lower border
	a_ok_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_OK |-> bin_q != '0)
		else $error("in-range result in bin zero");

endmodule

// ===== hdl/btint_div.sv =====
// bit-serial scaled ratio unit, floor(scale * num / den) for num < den
`timescale 1ns / 1ps

module btint_div import btint_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int NW = VALUE_BITS + COUNT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NW-1:0]    num,
	input  logic [NW-1:0]    den,
	output logic             done,
	output logic [PCT_W-1:0] quot
);

	logic             busy_q;
	logic             done_q;
	logic [BIT_W-1:0] bit_q;
	logic [NW-1:0]    num_q;
	logic [NW-1:0]    den_q;
	logic [NW-1:0]    rem_q;
	logic [PCT_W-1:0] quot_q;

	logic [NW+1:0]    sum;
	logic [NW+1:0]    den1;
	logic [NW+1:0]    den2;
	logic [NW-1:0]    rem_n;
	logic [1:0]       inc;

	// remainder stays below den, so one step subtracts at most twice
	always_comb begin
		den1 = (NW+2)'(den_q);
		den2 = {1'b0, den_q, 1'b0};
		sum  = {1'b0, rem_q, 1'b0} + (PERCENT_SCALE[bit_q] ? (NW+2)'(num_q) : '0);
		if (sum >= den2) begin
			rem_n = NW'(sum - den2);
			inc   = 2'd2;
		end else if (sum >= den1) begin
			rem_n = NW'(sum - den1);
			inc   = 2'd1;
		end else begin
			rem_n = NW'(sum);
			inc   = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= BIT_W'(PCT_W - 1);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_n;
			quot_q <= {quot_q[PCT_W-2:0], 1'b0} + PCT_W'(inc);
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== tb/tb_top.sv =====
// testbench for border_table_interpolator: random border tables and queries, self-checking
`timescale 1ns / 1ps

module tb_top;
	import btint_pkg::*;

	// result fields expected for one query
	typedef struct {
		status_t                 st;
		logic [COUNT_W-1:0]      bin;
		logic [PCT_W-1:0]        pct;
	} bin_result_t;

	// mirror of the border table and count, plus the queue of results still owed
	class bin_percent_board;
		logic [SAMPLE_W-1:0] border_copy [MAX_BORDERS_DEF];
		logic [COUNT_W-1:0]  count_copy;
		bin_result_t         owed_results [$];
		int unsigned         errors;

		function new();
			count_copy = '0;
			errors     = 0;
			foreach (border_copy[k]) border_copy[k] = '0;
		endfunction

		function void set_count(input logic [COUNT_W-1:0] c);
			count_copy = c;
		endfunction

		function int unsigned pending();
			return owed_results.size();
		endfunction

		// one accepted transaction on the item channel
		function void take_item(input command_t cmd, input logic [ENTRY_W-1:0] idx,
				input logic [SAMPLE_W-1:0] v);
			bin_result_t        r;
			int unsigned        n;
			int unsigned        j;
			longint unsigned    lo;
			longint unsigned    hi;
			longint unsigned    span;
			longint unsigned    num;
			longint unsigned    den;
			if (cmd == CMD_WRITE) begin
				border_copy[idx] = v;
				return;
			end
			r.st  = ST_OK;
			r.bin = '0;
			r.pct = '0;
			n = (int'(count_copy) > MAX_BORDERS_DEF) ? MAX_BORDERS_DEF : int'(count_copy);
			if (n < 3) begin
				r.st = ST_UNCFG;
			end else begin
				// first border strictly above the value
				j = 0;
				while (j < n && v >= border_copy[j]) j++;
				if (j == 0) begin
					r.st = ST_UNDER;
				end else if (j == n) begin
					r.st  = ST_OVER;
					r.bin = COUNT_W'(n);
				end else begin
					lo    = longint'(border_copy[j-1]);
					hi    = longint'(border_copy[j]);
					span  = hi - lo;
					num   = longint'(j - 1) * span + (longint'(v) - lo);
					den   = longint'(n - 1) * span;
					r.bin = COUNT_W'(j);
					r.pct = PCT_W'((64'(PERCENT_SCALE) * num) / den);
				end
			end
			owed_results.push_back(r);
		endfunction

		// one accepted transaction on the result channel
		function void check_result(input logic [STATUS_W-1:0] st, input logic [COUNT_W-1:0] bin,
				input logic [PCT_W-1:0] pct);
			bin_result_t r;
			if (owed_results.size() == 0) begin
				$error("result with nothing expected: status %0d bin %0d pct %0d", st, bin, pct);
				errors++;
				return;
			end
			r = owed_results.pop_front();
			if (st !== r.st) begin
				$error("status: expected %0d, got %0d", r.st, st);
				errors++;
			end
			if (bin !== r.bin) begin
				$error("bin_index: expected %0d, got %0d", r.bin, bin);
				errors++;
			end
			if (pct !== r.pct) begin
				$error("percent_q16: expected %0d, got %0d", r.pct, pct);
				errors++;
			end
		endfunction
	endclass

	// clock, reset and block ports; the driven inputs are known from time zero
	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic                command      = 1'b0;
	logic [ENTRY_W-1:0]  entry_index  = '0;
	logic [SAMPLE_W-1:0] sample_value = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  bin_index;
	logic [PCT_W-1:0]    percent_q16;
	logic                cfg_valid    = 1'b0;
	logic                cfg_ready;
	logic [COUNT_W-1:0]  border_count = '0;

	bin_percent_board board = new();

	// idling controls shared between sender and receiver
	int unsigned gap_pct       = 20;
	int unsigned rx_stall_pct  = 20;
	int unsigned hold_requests = 0;
	int unsigned holds_done    = 0;

	// border counts per random phase: too small, minimum, mid-size, full table, above the table size
	int unsigned phase_counts [12] = '{3, 64, 127, 2, 9, 65, 0, 33, 64, 5, 1, 48};

	border_table_interpolator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.entry_index  (entry_index),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.bin_index    (bin_index),
		.percent_q16  (percent_q16),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.border_count (border_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// offer one transaction and hold it until the block takes it
	task automatic put_item(input command_t cmd, input logic [ENTRY_W-1:0] idx,
			input logic [SAMPLE_W-1:0] val);
		in_valid     <= 1'b1;
		command      <= cmd;
		entry_index  <= idx;
		sample_value <= val;
		do @(posedge clk); while (in_stall);
		board.take_item(cmd, idx, val);
	endtask

	// with a chance of pct percent, a burst of empty cycles on the item channel
	task automatic sender_gap(input int unsigned pct);
		if (pct != 0 && $urandom_range(0, 99) < pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	// block idle: every result in and writes long since applied
	task automatic settle_idle();
		wait_results_done();
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] c);
		cfg_valid    <= 1'b1;
		border_count <= c;
		do @(posedge clk); while (!cfg_ready);
		board.set_count(c);
		cfg_valid <= 1'b0;
	endtask

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(0, 3))
			0: begin
				return 0;
			end
			1: begin
				return 10;
			end
			2: begin
				return 35;
			end
			default: begin
				return 70;
			end
		endcase
	endfunction

	// load entries 0..n-1 with an ascending table of a random flavour
	task automatic load_table(input int unsigned n);
		logic [SAMPLE_W-1:0] vals [$];
		logic [SAMPLE_W-1:0] step_max;
		logic [SAMPLE_W-1:0] acc;
		int unsigned         flavour;
		flavour = $urandom_range(0, 2);
		if (flavour == 0) begin
			// wide spread, sometimes pinned to the ends of the value range
			for (int k = 0; k < n; k++) vals.push_back($urandom);
			vals.sort();
			if ($urandom_range(0, 3) == 0) vals[0] = '0;
			if ($urandom_range(0, 3) == 0) vals[n-1] = '1;
		end else begin
			// tight spans of a few counts, or medium spans with repeated borders
			step_max = (flavour == 1) ? 32'd3 : 32'h0100_0000;
			acc = $urandom_range(0, 32'hFFFF_FFFF - 64 * step_max);
			for (int k = 0; k < n; k++) begin
				vals.push_back(acc);
				acc = acc + $urandom_range((flavour == 1) ? 1 : 0, step_max);
			end
		end
		for (int k = 0; k < n; k++) begin
			sender_gap(gap_pct);
			put_item(CMD_WRITE, ENTRY_W'(k), vals[k]);
		end
	endtask

	// query values aimed mostly inside bins, the rest at borders, outside the table or anywhere
	function automatic logic [SAMPLE_W-1:0] pick_query(input int unsigned n);
		int unsigned         sel;
		int unsigned         k;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		if (n < 3) return $urandom;
		sel = $urandom_range(0, 99);
		k   = $urandom_range(1, n - 1);
		lo  = board.border_copy[k-1];
		hi  = board.border_copy[k];
		if (sel < 60) begin
			if (hi > lo) begin
				case ($urandom_range(0, 3))
					0: begin
						return lo;
					end
					1: begin
						return hi - 1;
					end
					default: begin
						return lo + $urandom_range(0, hi - lo - 1);
					end
				endcase
			end
			return lo;
		end
		if (sel < 70) return board.border_copy[$urandom_range(0, n - 1)];
		if (sel < 80) begin
			if (board.border_copy[0] == '0) return '0;
			return $urandom_range(0, board.border_copy[0] - 1);
		end
		if (sel < 90) begin
			return board.border_copy[n-1] + $urandom_range(0, 32'hFFFF_FFFF - board.border_copy[n-1]);
		end
		return $urandom;
	endfunction

	// result side: check every transaction, stall in bursts, and do the long hold-off on request
	initial begin
		int unsigned burst_left;
		int unsigned hold_left;
		burst_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				board.check_result(status, bin_index, percent_q16);
			end
			if (holds_done < hold_requests) begin
				holds_done = holds_done + 1;
				hold_left  = 300;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else if (burst_left != 0) begin
				burst_left = burst_left - 1;
				out_stall <= 1'b1;
			end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				burst_left = $urandom_range(0, 18);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// item side: directed checks, then random phases with a fresh count each
	initial begin
		int unsigned n_eff;
		int unsigned n_items;
		int unsigned wait_cycles;
		bit          last_phase;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count still zero after reset: not configured at both value extremes
		put_item(CMD_QUERY, ENTRY_W'(0), 32'd0);
		put_item(CMD_QUERY, ENTRY_W'(63), 32'hFFFF_FFFF);
		settle_idle();
		write_count(COUNT_W'(2));
		put_item(CMD_QUERY, ENTRY_W'(0), 32'h8000_0000);

		// four borders, one of them near the top of the range, plus the last entry
		settle_idle();
		write_count(COUNT_W'(4));
		put_item(CMD_WRITE, ENTRY_W'(0), 32'd10);
		put_item(CMD_WRITE, ENTRY_W'(1), 32'd20);
		put_item(CMD_WRITE, ENTRY_W'(2), 32'd1000);
		put_item(CMD_WRITE, ENTRY_W'(3), 32'hFFFF_FFF0);
		put_item(CMD_WRITE, ENTRY_W'(63), 32'hFFFF_FFFF);
		// below the first border, on each border, just under each border, past the last
		put_item(CMD_QUERY, ENTRY_W'(0), 32'd0);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'd9);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'd10);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'd19);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'd20);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'd999);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'd1000);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'hFFFF_FFEF);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'hFFFF_FFF0);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'hFFFF_FFFF);
		// table no longer ascending: second border drops below the first
		put_item(CMD_WRITE, ENTRY_W'(1), 32'd5);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'd10);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'd7);
		put_item(CMD_QUERY, ENTRY_W'(0), 32'd4);

		foreach (phase_counts[p]) begin
			last_phase = (p == $size(phase_counts) - 1);
			settle_idle();
			write_count(COUNT_W'(phase_counts[p]));
			n_eff = (phase_counts[p] > MAX_BORDERS_DEF) ? MAX_BORDERS_DEF : phase_counts[p];
			// final phase runs with no idling at all
			gap_pct = last_phase ? 0 : pick_idle_pct();
			rx_stall_pct <= last_phase ? 0 : pick_idle_pct();
			if (n_eff >= 3) load_table(n_eff);
			n_items = (n_eff < 3) ? 40 : 65;
			for (int i = 0; i < n_items; i++) begin
				// receiver holds off for a long stretch while items keep coming
				if (p == 1 && i == 30) hold_requests <= hold_requests + 1;
				// sender stops until the block has handed back everything
				if (p == 2 && i == 45) wait_results_done();
				sender_gap(gap_pct);
				if ($urandom_range(0, 9) == 0) begin
					put_item(CMD_WRITE, ENTRY_W'($urandom_range(0, 63)), $urandom);
				end else begin
					put_item(CMD_QUERY, ENTRY_W'($urandom_range(0, 63)), pick_query(n_eff));
				end
			end
		end

		// drain with a bound, then allow for the longest in-range search
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (board.pending() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		if (board.pending() != 0) begin
			$error("%0d expected results never arrived", board.pending());
		end
		if (board.errors == 0 && board.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/btint_pkg.sv
hdl/btint_div.sv
hdl/border_table_interpolator.sv
tb/tb_top.sv
